/* rtl/tlr_pkg.sv */
// Shared constants and codes for the thick line rasterizer.
package tlr_pkg;

  // Configuration register file
  localparam int REG_BITS     = 13;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [REG_BITS-1:0] IMAGE_WIDTH_RESET  = 13'd640;
  localparam logic [REG_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;

  // Item kinds on the input tuser bit
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Fixed field widths
  localparam int THICK_BITS  = 4;
  localparam int COLOUR_BITS = 24;
  localparam int ADDR_BITS   = 26;

  // Parameter defaults
  localparam int COORD_BITS_DEFAULT    = 13;
  localparam int MAX_THICKNESS_DEFAULT = 15;

endpackage

/* rtl/tlr_line_engine.sv */
// Bresenham line state, shifted-line setup and the pixel stage register.
module tlr_line_engine
  import tlr_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEFAULT,
  parameter int MAX_THICKNESS = MAX_THICKNESS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_mode_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [THICK_BITS-1:0]        thickness_i,
  input  logic [COLOUR_BITS-1:0]       colour_i,
  output logic                         ready_o,
  input  logic                         down_ready_i,
  output logic                         pix_valid_o,
  output logic signed [COORD_BITS:0]   pix_x_o,
  output logic signed [COORD_BITS:0]   pix_y_o,
  output logic [COLOUR_BITS-1:0]       pix_colour_o,
  output logic                         pix_last_o
);

  localparam int PW    = COORD_BITS + 1;
  localparam int EW    = COORD_BITS + 2;
  localparam int OFF_W = (MAX_THICKNESS > 0) ? $clog2(2 * MAX_THICKNESS + 1) : 1;
  localparam int ST_W  = (MAX_THICKNESS > 0) ? $clog2(MAX_THICKNESS + 1) : 1;
  localparam int IW    = OFF_W + 1;

  // Line state
  logic                         active_q, active_d;
  logic [OFF_W-1:0]             offset_q, offset_d;
  logic signed [COORD_BITS-1:0] ep_q [4];
  logic signed [COORD_BITS-1:0] ep_d [4];
  logic [ST_W-1:0]              thick_q, thick_d;
  logic signed [PW-1:0]         major_q, major_d;
  logic signed [PW-1:0]         minor_q, minor_d;
  logic signed [PW-1:0]         major_end_q, major_end_d;
  logic signed [EW-1:0]         err_q, err_d;
  logic signed [EW-1:0]         inc_ns_q, inc_ns_d;
  logic signed [EW-1:0]         inc_st_q, inc_st_d;
  logic                         steep_q, steep_d;
  logic [1:0]                   signs_q, signs_d;
  logic [COLOUR_BITS-1:0]       colour_q, colour_d;

  // Pixel stage
  logic                         s1_valid_q, s1_valid_d;
  logic signed [PW-1:0]         s1_x_q, s1_y_q;
  logic [COLOUR_BITS-1:0]       s1_colour_q;
  logic                         s1_last_q;

  logic accept, is_start, is_step, at_end, fin;

  // Setup source and result
  logic signed [COORD_BITS-1:0] src_x1, src_y1, src_x2, src_y2;
  logic [THICK_BITS-1:0]        t_in;
  logic [ST_W-1:0]              t_sat, t_src;
  logic [OFF_W-1:0]             k_src;
  logic signed [IW-1:0]         shift;
  logic signed [PW-1:0]         x1, y1, x2, y2, dxs, dys, adx, ady;
  logic signed [PW-1:0]         dmaj, dmin, maj_diff, min_diff;
  logic                         su_steep;
  logic signed [PW-1:0]         su_major, su_minor, su_end;
  logic signed [EW-1:0]         su_err, su_inc_ns, su_inc_st;
  logic [1:0]                   su_signs;

  assign ready_o  = !s1_valid_q || down_ready_i;
  assign accept   = in_valid_i && ready_o;
  assign is_start = accept && (in_mode_i == MODE_START);
  assign is_step  = accept && (in_mode_i == MODE_STEP) && active_q;
  assign at_end   = (major_q == major_end_q);
  assign fin      = at_end && ({1'b0, offset_q} >= ((OFF_W + 1)'(thick_q) << 1));

  assign t_in  = thickness_i;
  assign t_sat = (int'(t_in) > MAX_THICKNESS) ? ST_W'(MAX_THICKNESS) : ST_W'(t_in);

  // Shifted-line setup, shared by a start and by the move to the next line
  always_comb begin
    src_x1 = is_start ? start_x_i : ep_q[0];
    src_y1 = is_start ? start_y_i : ep_q[1];
    src_x2 = is_start ? end_x_i : ep_q[2];
    src_y2 = is_start ? end_y_i : ep_q[3];
    t_src  = is_start ? t_sat : thick_q;
    k_src  = is_start ? '0 : offset_q + OFF_W'(1);
    shift  = $signed({1'b0, k_src}) - IW'($signed({1'b0, t_src}));

    x1  = PW'(src_x1) + PW'(shift);
    y1  = PW'(src_y1) + PW'(shift);
    x2  = PW'(src_x2) + PW'(shift);
    y2  = PW'(src_y2) + PW'(shift);
    dxs = x2 - x1;
    dys = y2 - y1;
    adx = dxs[PW-1] ? -dxs : dxs;
    ady = dys[PW-1] ? -dys : dys;

    su_steep = adx < ady;
    su_major = su_steep ? y1 : x1;
    su_minor = su_steep ? x1 : y1;
    su_end   = su_steep ? y2 : x2;
    maj_diff = su_steep ? dys : dxs;
    min_diff = su_steep ? dxs : dys;
    dmaj     = su_steep ? ady : adx;
    dmin     = su_steep ? adx : ady;

    // direction bit set when the difference is zero or negative
    su_signs  = {!(min_diff > 0), !(maj_diff > 0)};
    su_inc_ns = EW'(dmin) <<< 1;
    su_inc_st = (EW'(dmin) - EW'(dmaj)) <<< 1;
    su_err    = (EW'(dmin) <<< 1) - EW'(dmaj);
  end

  always_comb begin
    active_d    = active_q;
    offset_d    = offset_q;
    ep_d        = ep_q;
    thick_d     = thick_q;
    major_d     = major_q;
    minor_d     = minor_q;
    major_end_d = major_end_q;
    err_d       = err_q;
    inc_ns_d    = inc_ns_q;
    inc_st_d    = inc_st_q;
    steep_d     = steep_q;
    signs_d     = signs_q;
    colour_d    = colour_q;

    if (is_start || (is_step && at_end && !fin)) begin
      major_d     = su_major;
      minor_d     = su_minor;
      major_end_d = su_end;
      err_d       = su_err;
      inc_ns_d    = su_inc_ns;
      inc_st_d    = su_inc_st;
      steep_d     = su_steep;
      signs_d     = su_signs;
      offset_d    = k_src;
    end

    if (is_start) begin
      ep_d[0]  = start_x_i;
      ep_d[1]  = start_y_i;
      ep_d[2]  = end_x_i;
      ep_d[3]  = end_y_i;
      thick_d  = t_sat;
      colour_d = colour_i;
      active_d = 1'b1;
    end else if (is_step) begin
      if (fin) begin
        active_d = 1'b0;
      end else if (!at_end) begin
        // a zero error term steps the minor axis
        if (err_q[EW-1]) begin
          err_d = err_q + inc_ns_q;
        end else begin
          minor_d = signs_q[1] ? minor_q - PW'(1) : minor_q + PW'(1);
          err_d   = err_q + inc_st_q;
        end
        major_d = signs_q[0] ? major_q - PW'(1) : major_q + PW'(1);
      end
    end
  end

  assign s1_valid_d = ready_o ? is_step : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      offset_q    <= '0;
      for (int n = 0; n < 4; n++) ep_q[n] <= '0;
      thick_q     <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      major_end_q <= '0;
      err_q       <= '0;
      inc_ns_q    <= '0;
      inc_st_q    <= '0;
      steep_q     <= 1'b0;
      signs_q     <= '0;
      colour_q    <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      active_q    <= active_d;
      offset_q    <= offset_d;
      ep_q        <= ep_d;
      thick_q     <= thick_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      major_end_q <= major_end_d;
      err_q       <= err_d;
      inc_ns_q    <= inc_ns_d;
      inc_st_q    <= inc_st_d;
      steep_q     <= steep_d;
      signs_q     <= signs_d;
      colour_q    <= colour_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_step) begin
      s1_x_q      <= steep_q ? minor_q : major_q;
      s1_y_q      <= steep_q ? major_q : minor_q;
      s1_colour_q <= colour_q;
      s1_last_q   <= fin;
    end
  end

  assign pix_valid_o  = s1_valid_q;
  assign pix_x_o      = s1_x_q;
  assign pix_y_o      = s1_y_q;
  assign pix_colour_o = s1_colour_q;
  assign pix_last_o   = s1_last_q;

endmodule

/* rtl/tlr_pixel_out.sv */
// Bounds check, frame buffer byte address and the result register.
module tlr_pixel_out
  import tlr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pix_valid_i,
  input  logic signed [COORD_BITS:0] pix_x_i,
  input  logic signed [COORD_BITS:0] pix_y_i,
  input  logic [COLOUR_BITS-1:0]     pix_colour_i,
  input  logic                       pix_last_i,
  input  logic [REG_BITS-1:0]        image_width_i,
  input  logic [REG_BITS-1:0]        image_height_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [COORD_BITS:0] out_x_o,
  output logic signed [COORD_BITS:0] out_y_o,
  output logic [ADDR_BITS-1:0]       out_addr_o,
  output logic                       out_inside_o,
  output logic [COLOUR_BITS-1:0]     out_colour_o,
  output logic                       out_last_o
);

  localparam int PW = COORD_BITS + 1;
  localparam int UW = (PW > REG_BITS) ? PW : REG_BITS;
  localparam int MW = COORD_BITS + REG_BITS;

  logic                   valid_q, valid_d;
  logic signed [PW-1:0]   x_q, y_q;
  logic [ADDR_BITS-1:0]   addr_q;
  logic                   inside_q;
  logic [COLOUR_BITS-1:0] colour_q;
  logic                   last_q;

  logic                 in_image;
  logic [MW-1:0]        row_prod;
  logic [ADDR_BITS-1:0] pix_index, addr;

  assign ready_o = !valid_q || out_ready_i;
  assign valid_d = ready_o ? pix_valid_i : valid_q;

  always_comb begin
    in_image = !pix_x_i[PW-1] && !pix_y_i[PW-1]
          && (UW'($unsigned(pix_x_i)) < UW'(image_width_i))
          && (UW'($unsigned(pix_y_i)) < UW'(image_height_i));
    row_prod  = MW'(pix_y_i[COORD_BITS-1:0]) * MW'(image_width_i);
    pix_index = ADDR_BITS'(row_prod) + ADDR_BITS'(pix_x_i[COORD_BITS-1:0]);
    // three bytes per pixel; wraps at the address width
    addr      = in_image ? pix_index + (pix_index << 1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && pix_valid_i) begin
      x_q      <= pix_x_i;
      y_q      <= pix_y_i;
      addr_q   <= addr;
      inside_q <= in_image;
      colour_q <= pix_colour_i;
      last_q   <= pix_last_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_x_o      = x_q;
  assign out_y_o      = y_q;
  assign out_addr_o   = addr_q;
  assign out_inside_o = inside_q;
  assign out_colour_o = colour_q;
  assign out_last_o   = last_q;

endmodule

/* rtl/thick_line_rasterizer.sv */
// Thick line rasterizer top level: stream ports, image size registers, assertions.
//
//  channel   dir  beat content
//  s_axis    in   tuser: mode; tdata: start/end x,y, thickness, blue, green, red
//  m_axis    out  tuser: inside; tlast: last; tdata: x, y, address, colour
//  cfg       in   cfg_we_i / cfg_index_i / cfg_data_i, write only
//
// One input beat per cycle while s_axis_tready is high. A step beat's pixel
// passes from the line state into the pixel stage, then the row multiply and
// bounds check fill the result register that drives m_axis.
// A start beat and a step beat with no line running produce nothing.
// Reset clears the line state and valid flags and loads 640 x 480.
// A stalled m_axis holds the result register; s_axis_tready drops only when
// both the pixel stage and the result register are full.
module thick_line_rasterizer
  import tlr_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEFAULT,
  parameter int MAX_THICKNESS = MAX_THICKNESS_DEFAULT,
  localparam int IN_BITS      = 4 * COORD_BITS + THICK_BITS + COLOUR_BITS,
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS     = 2 * (COORD_BITS + 1) + ADDR_BITS + COLOUR_BITS,
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // start_x, start_y, end_x, end_y, thickness, blue, green, red
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // pixel_x, pixel_y, pixel_address, out_blue, out_green, out_red
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  // inside_res
  output logic                    m_axis_tuser,
  output logic                    m_axis_tlast,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [REG_BITS-1:0]     cfg_data_i
);

  localparam int THICK_LSB  = 4 * COORD_BITS;
  localparam int COLOUR_LSB = THICK_LSB + THICK_BITS;

  logic [REG_BITS-1:0] width_q, height_q;

  logic                         eng_ready, out_stage_ready;
  logic                         pix_valid, pix_last;
  logic signed [COORD_BITS:0]   pix_x, pix_y;
  logic [COLOUR_BITS-1:0]       pix_colour;
  logic signed [COORD_BITS:0]   out_x, out_y;
  logic [ADDR_BITS-1:0]         out_addr;
  logic [COLOUR_BITS-1:0]       out_colour;
  logic                         out_inside, out_last, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RESET;
      height_q <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tlr_line_engine #(
    .COORD_BITS    (COORD_BITS),
    .MAX_THICKNESS (MAX_THICKNESS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_mode_i    (s_axis_tuser),
    .start_x_i    ($signed(s_axis_tdata[0 +: COORD_BITS])),
    .start_y_i    ($signed(s_axis_tdata[COORD_BITS +: COORD_BITS])),
    .end_x_i      ($signed(s_axis_tdata[2*COORD_BITS +: COORD_BITS])),
    .end_y_i      ($signed(s_axis_tdata[3*COORD_BITS +: COORD_BITS])),
    .thickness_i  (s_axis_tdata[THICK_LSB +: THICK_BITS]),
    .colour_i     (s_axis_tdata[COLOUR_LSB +: COLOUR_BITS]),
    .ready_o      (eng_ready),
    .down_ready_i (out_stage_ready),
    .pix_valid_o  (pix_valid),
    .pix_x_o      (pix_x),
    .pix_y_o      (pix_y),
    .pix_colour_o (pix_colour),
    .pix_last_o   (pix_last)
  );

  tlr_pixel_out #(
    .COORD_BITS (COORD_BITS)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_valid_i    (pix_valid),
    .pix_x_i        (pix_x),
    .pix_y_i        (pix_y),
    .pix_colour_i   (pix_colour),
    .pix_last_i     (pix_last),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .ready_o        (out_stage_ready),
    .out_valid_o    (out_valid),
    .out_ready_i    (m_axis_tready),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_addr_o     (out_addr),
    .out_inside_o   (out_inside),
    .out_colour_o   (out_colour),
    .out_last_o     (out_last)
  );

  assign s_axis_tready = eng_ready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({out_colour, out_addr, out_y, out_x});
  assign m_axis_tuser  = out_inside;
  assign m_axis_tlast  = out_last;

  // Input backpressure only comes from a stalled, full output side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output side can drain");

  // Pixels outside the image carry a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_inside |-> out_addr == '0)
    else $error("outside pixel with nonzero address");

  // An inside pixel needs a nonempty image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_inside |-> width_q != '0 && height_q != '0)
    else $error("inside flag set for an empty image");

endmodule
